// File: rtl/dtdc_pkg.sv
// dtdc_pkg: shared types, constants and the month length table of the
// calendar difference unit. No dependencies; used by every rtl file.
`timescale 1ns / 1ps

package dtdc_pkg;

   localparam int FIRST_YEAR_INT = 1970;
   localparam int LAST_YEAR_INT  = 2099;

   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;

   // signed day count and signed seconds-of-day accumulators
   localparam int DAYS_W = 17;
   localparam int TOD_W  = 18;
   localparam int BIT_W  = 3;

   localparam logic [YEAR_W-1:0] FIRST_YEAR = YEAR_W'(FIRST_YEAR_INT);
   localparam logic [YEAR_W-1:0] LAST_YEAR  = YEAR_W'(LAST_YEAR_INT);

   // leap rule counters, seeded with the first year's residues
   localparam logic [1:0] FIRST_MOD4   = 2'(FIRST_YEAR_INT % 4);
   localparam logic [6:0] FIRST_MOD100 = 7'(FIRST_YEAR_INT % 100);
   localparam logic [8:0] FIRST_MOD400 = 9'(FIRST_YEAR_INT % 400);
   localparam logic [6:0] LAST_MOD100  = 7'd99;
   localparam logic [8:0] LAST_MOD400  = 9'd399;

   localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd12;

   localparam logic signed [DAYS_W-1:0] DAYS_COMMON = 17'sd365;
   localparam logic signed [DAYS_W-1:0] DAYS_LEAP   = 17'sd366;
   localparam logic signed [TOD_W-1:0]  SEC_PER_DAY  = 18'sd86400;
   localparam logic signed [TOD_W-1:0]  SEC_PER_HOUR = 18'sd3600;
   localparam logic signed [TOD_W-1:0]  SEC_PER_MIN  = 18'sd60;

   // highest quotient bit of the hour and minute digit loops
   localparam logic [BIT_W-1:0] HOUR_TOP_BIT = 3'd4;
   localparam logic [BIT_W-1:0] MIN_TOP_BIT  = 3'd5;

   typedef struct packed {
      logic [SEC_W-1:0]   second;
      logic [MIN_W-1:0]   minute;
      logic [HOUR_W-1:0]  hour;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } dtdc_dt_type;

   localparam int DT_W = $bits(dtdc_dt_type);
   localparam int REQ_W = ((2 * DT_W + 7) / 8) * 8;
   localparam int RSP_W = ((DT_W + 7) / 8) * 8;

   typedef struct packed {
      logic [REQ_W-2*DT_W-1:0] pad;
      dtdc_dt_type             b;
      dtdc_dt_type             a;
   } dtdc_req_type;

   typedef struct packed {
      logic [RSP_W-DT_W-1:0] pad;
      dtdc_dt_type           diff;
   } dtdc_rsp_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_YEAR_IN,
      OP_MONTH_IN,
      OP_NORM,
      OP_HOUR,
      OP_MIN,
      OP_YEAR_OUT,
      OP_MONTH_OUT,
      OP_FINISH
   } dtdc_op_type;

   typedef struct packed {
      dtdc_op_type op;
      logic        load;
      logic        out_load;
   } dtdc_cmd_type;

   typedef struct packed {
      logic year_in_done;
      logic month_in_done;
      logic norm_done;
      logic div_last;
      logic year_out_done;
      logic month_out_done;
      logic negative;
   } dtdc_status_type;

   function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                   input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] len;
      len = '0;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         4'd2:                                      len = leap ? 5'd29 : 5'd28;
         default:                                   len = '0;
      endcase
      return len;
   endfunction

endpackage

// File: rtl/datetime_difference_calendar_unit.sv
// datetime_difference_calendar_unit: top level joining dtdc_ctrl and
// dtdc_datapath. Uses dtdc_pkg for the word layouts.
//
// Usage: each request word carries two date-times a and b; the response word
// gives a minus b in calendar form counted from 1970-01-01 00:00:00, with
// rsp_tuser set (and the fields at the epoch) when a precedes b.
// One word is worked on at a time. req_tready is high only while the unit is
// idle; after a word is taken the unit runs its year loop and its month loop,
// carries seconds into days, works out the hour and then the minute digits,
// runs the result year loop and month loop, then loads the result register.
// The latency is set by the year counters; a negative difference skips the
// digit and output loops. The next word can be taken in the cycle after the
// result is loaded. Reset (synchronous, active high) returns the sequencer to
// idle and clears rsp_tvalid. The result sits in an output register: a new
// request word is accepted while an earlier result waits, and the unit only
// stalls before loading its next result if rsp_tready is still low.
`timescale 1ns / 1ps

module datetime_difference_calendar_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // a_year, a_month, a_day, a_hour, a_minute, a_second,
   // b_year, b_month, b_day, b_hour, b_minute, b_second, zero fill
   input  logic [dtdc_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // diff_year, diff_month, diff_day, diff_hour, diff_minute, diff_second, zero fill
   output logic [dtdc_pkg::RSP_W-1:0] rsp_tdata,
   // negative
   output logic [0:0]                 rsp_tuser
);

   dtdc_pkg::dtdc_cmd_type    cmd;
   dtdc_pkg::dtdc_status_type status;
   dtdc_pkg::dtdc_req_type    req_word;
   dtdc_pkg::dtdc_rsp_type    rsp_word;
   logic                      rsp_neg;

   assign req_word = dtdc_pkg::dtdc_req_type'(req_tdata);

   dtdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   dtdc_datapath u_datapath (
      .clock    (clock),
      .req_word (req_word),
      .cmd      (cmd),
      .status   (status),
      .rsp_word (rsp_word),
      .rsp_neg  (rsp_neg)
   );

   assign rsp_tdata    = rsp_word;
   assign rsp_tuser[0] = rsp_neg;

endmodule

// File: rtl/dtdc_datapath.sv
// dtdc_datapath: day and seconds accumulators, year/month counters with leap
// tracking, hour/minute digit loop and the result register. Uses dtdc_pkg.
`timescale 1ns / 1ps

module dtdc_datapath (
   input  logic                     clock,
   input  dtdc_pkg::dtdc_req_type   req_word,
   input  dtdc_pkg::dtdc_cmd_type   cmd,
   output dtdc_pkg::dtdc_status_type status,
   output dtdc_pkg::dtdc_rsp_type   rsp_word,
   output logic                     rsp_neg
);

   logic [dtdc_pkg::YEAR_W-1:0]  yr_a_ff, yr_a_in, yr_b_ff, yr_b_in;
   logic [dtdc_pkg::MONTH_W-1:0] mo_a_ff, mo_a_in, mo_b_ff, mo_b_in;
   logic                         leap_a_ff, leap_a_in, leap_b_ff, leap_b_in;
   logic [dtdc_pkg::YEAR_W-1:0]  yc_ff, yc_in;
   logic [1:0]                   m4_ff, m4_in;
   logic [6:0]                   m100_ff, m100_in;
   logic [8:0]                   m400_ff, m400_in;
   logic [dtdc_pkg::MONTH_W-1:0] mc_ff, mc_in;
   logic signed [dtdc_pkg::DAYS_W-1:0] days_ff, days_in;
   logic signed [dtdc_pkg::TOD_W-1:0]  tod_ff, tod_in;
   logic [dtdc_pkg::BIT_W-1:0]   k_ff, k_in;
   logic [dtdc_pkg::HOUR_W-1:0]  hr_ff, hr_in;
   logic [dtdc_pkg::MIN_W-1:0]   mn_ff, mn_in;
   dtdc_pkg::dtdc_rsp_type       out_ff, out_in;
   logic                         neg_ff, neg_in;

   logic                               leap_now;
   logic signed [dtdc_pkg::DAYS_W-1:0] ylen, dim_a, dim_b, dim_now;
   logic                               ystep_a, ystep_b, mstep_a, mstep_b;
   logic signed [dtdc_pkg::TOD_W-1:0]  div_sel, trial;
   logic signed [5:0]                  hd;
   logic signed [6:0]                  md, sd;

   assign leap_now = (m4_ff == 2'd0) && ((m100_ff != 7'd0) || (m400_ff == 9'd0));
   assign ylen     = leap_now ? dtdc_pkg::DAYS_LEAP : dtdc_pkg::DAYS_COMMON;
   assign dim_a    = $signed(dtdc_pkg::DAYS_W'(dtdc_pkg::month_days(leap_a_ff, mc_ff)));
   assign dim_b    = $signed(dtdc_pkg::DAYS_W'(dtdc_pkg::month_days(leap_b_ff, mc_ff)));
   assign dim_now  = $signed(dtdc_pkg::DAYS_W'(dtdc_pkg::month_days(leap_now, mc_ff)));

   assign ystep_a = yc_ff < yr_a_ff;
   assign ystep_b = yc_ff < yr_b_ff;
   // months past december add nothing
   assign mstep_a = (mc_ff < mo_a_ff) && (mc_ff <= dtdc_pkg::LAST_MONTH);
   assign mstep_b = (mc_ff < mo_b_ff) && (mc_ff <= dtdc_pkg::LAST_MONTH);

   assign div_sel = (cmd.op == dtdc_pkg::OP_HOUR) ? dtdc_pkg::SEC_PER_HOUR
                                                  : dtdc_pkg::SEC_PER_MIN;
   assign trial   = tod_ff - (div_sel <<< k_ff);

   assign hd = $signed({1'b0, req_word.a.hour}) - $signed({1'b0, req_word.b.hour});
   assign md = $signed({1'b0, req_word.a.minute}) - $signed({1'b0, req_word.b.minute});
   assign sd = $signed({1'b0, req_word.a.second}) - $signed({1'b0, req_word.b.second});

   always_comb begin
      status.year_in_done   = !ystep_a && !ystep_b;
      status.month_in_done  = !mstep_a && !mstep_b;
      status.norm_done      = (tod_ff >= 0) && (tod_ff < dtdc_pkg::SEC_PER_DAY);
      status.div_last       = (k_ff == '0);
      status.year_out_done  = days_ff < ylen;
      status.month_out_done = days_ff < dim_now;
      status.negative       = days_ff[dtdc_pkg::DAYS_W-1];
   end

   always_comb begin
      yr_a_in   = yr_a_ff;
      yr_b_in   = yr_b_ff;
      mo_a_in   = mo_a_ff;
      mo_b_in   = mo_b_ff;
      leap_a_in = leap_a_ff;
      leap_b_in = leap_b_ff;
      yc_in     = yc_ff;
      m4_in     = m4_ff;
      m100_in   = m100_ff;
      m400_in   = m400_ff;
      mc_in     = mc_ff;
      days_in   = days_ff;
      tod_in    = tod_ff;
      k_in      = k_ff;
      hr_in     = hr_ff;
      mn_in     = mn_ff;
      out_in    = out_ff;
      neg_in    = neg_ff;

      if (cmd.load) begin
         priority if (req_word.a.year < dtdc_pkg::FIRST_YEAR) yr_a_in = dtdc_pkg::FIRST_YEAR;
         else if (req_word.a.year > dtdc_pkg::LAST_YEAR)      yr_a_in = dtdc_pkg::LAST_YEAR;
         else                                                 yr_a_in = req_word.a.year;
         priority if (req_word.b.year < dtdc_pkg::FIRST_YEAR) yr_b_in = dtdc_pkg::FIRST_YEAR;
         else if (req_word.b.year > dtdc_pkg::LAST_YEAR)      yr_b_in = dtdc_pkg::LAST_YEAR;
         else                                                 yr_b_in = req_word.b.year;
         mo_a_in = req_word.a.month;
         mo_b_in = req_word.b.month;
         // the day-1 terms cancel in the difference
         days_in = dtdc_pkg::DAYS_W'($signed({1'b0, req_word.a.day}))
                 - dtdc_pkg::DAYS_W'($signed({1'b0, req_word.b.day}));
         tod_in  = dtdc_pkg::TOD_W'(hd) * dtdc_pkg::SEC_PER_HOUR
                 + dtdc_pkg::TOD_W'(md) * dtdc_pkg::SEC_PER_MIN
                 + dtdc_pkg::TOD_W'(sd);
         yc_in   = dtdc_pkg::FIRST_YEAR;
         m4_in   = dtdc_pkg::FIRST_MOD4;
         m100_in = dtdc_pkg::FIRST_MOD100;
         m400_in = dtdc_pkg::FIRST_MOD400;
         mc_in   = 4'd1;
      end

      unique case (cmd.op)
         dtdc_pkg::OP_YEAR_IN: begin
            if (yc_ff == yr_a_ff) leap_a_in = leap_now;
            if (yc_ff == yr_b_ff) leap_b_in = leap_now;
            if (!status.year_in_done) begin
               days_in = days_ff + (ystep_a ? ylen : '0) - (ystep_b ? ylen : '0);
               yc_in   = yc_ff + 1'b1;
               m4_in   = m4_ff + 1'b1;
               m100_in = (m100_ff == dtdc_pkg::LAST_MOD100) ? '0 : m100_ff + 1'b1;
               m400_in = (m400_ff == dtdc_pkg::LAST_MOD400) ? '0 : m400_ff + 1'b1;
            end
         end
         dtdc_pkg::OP_MONTH_IN: begin
            if (!status.month_in_done) begin
               days_in = days_ff + (mstep_a ? dim_a : '0) - (mstep_b ? dim_b : '0);
               mc_in   = mc_ff + 1'b1;
            end
         end
         dtdc_pkg::OP_NORM: begin
            // bring seconds into one day, carrying into the day count
            if (tod_ff < 0) begin
               tod_in  = tod_ff + dtdc_pkg::SEC_PER_DAY;
               days_in = days_ff - 17'sd1;
            end else if (tod_ff >= dtdc_pkg::SEC_PER_DAY) begin
               tod_in  = tod_ff - dtdc_pkg::SEC_PER_DAY;
               days_in = days_ff + 17'sd1;
            end
            k_in    = dtdc_pkg::HOUR_TOP_BIT;
            hr_in   = '0;
            mn_in   = '0;
            yc_in   = dtdc_pkg::FIRST_YEAR;
            m4_in   = dtdc_pkg::FIRST_MOD4;
            m100_in = dtdc_pkg::FIRST_MOD100;
            m400_in = dtdc_pkg::FIRST_MOD400;
         end
         dtdc_pkg::OP_HOUR: begin
            if (trial >= 0) begin
               tod_in = trial;
               hr_in  = hr_ff | (dtdc_pkg::HOUR_W'(1) << k_ff);
            end
            k_in = status.div_last ? dtdc_pkg::MIN_TOP_BIT : k_ff - 1'b1;
         end
         dtdc_pkg::OP_MIN: begin
            if (trial >= 0) begin
               tod_in = trial;
               mn_in  = mn_ff | (dtdc_pkg::MIN_W'(1) << k_ff);
            end
            k_in = k_ff - 1'b1;
         end
         dtdc_pkg::OP_YEAR_OUT: begin
            mc_in = 4'd1;
            if (!status.year_out_done) begin
               days_in = days_ff - ylen;
               yc_in   = yc_ff + 1'b1;
               m4_in   = m4_ff + 1'b1;
               m100_in = (m100_ff == dtdc_pkg::LAST_MOD100) ? '0 : m100_ff + 1'b1;
               m400_in = (m400_ff == dtdc_pkg::LAST_MOD400) ? '0 : m400_ff + 1'b1;
            end
         end
         dtdc_pkg::OP_MONTH_OUT: begin
            if (!status.month_out_done) begin
               days_in = days_ff - dim_now;
               mc_in   = mc_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (cmd.out_load) begin
         out_in.pad = '0;
         neg_in     = status.negative;
         if (status.negative) begin
            out_in.diff.year   = dtdc_pkg::FIRST_YEAR;
            out_in.diff.month  = 4'd1;
            out_in.diff.day    = 5'd1;
            out_in.diff.hour   = '0;
            out_in.diff.minute = '0;
            out_in.diff.second = '0;
         end else begin
            out_in.diff.year   = yc_ff;
            out_in.diff.month  = mc_ff;
            out_in.diff.day    = days_ff[dtdc_pkg::DAY_W-1:0] + 5'd1;
            out_in.diff.hour   = hr_ff;
            out_in.diff.minute = mn_ff;
            out_in.diff.second = tod_ff[dtdc_pkg::SEC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      yr_a_ff   <= yr_a_in;
      yr_b_ff   <= yr_b_in;
      mo_a_ff   <= mo_a_in;
      mo_b_ff   <= mo_b_in;
      leap_a_ff <= leap_a_in;
      leap_b_ff <= leap_b_in;
      yc_ff     <= yc_in;
      m4_ff     <= m4_in;
      m100_ff   <= m100_in;
      m400_ff   <= m400_in;
      mc_ff     <= mc_in;
      days_ff   <= days_in;
      tod_ff    <= tod_in;
      k_ff      <= k_in;
      hr_ff     <= hr_in;
      mn_ff     <= mn_in;
      out_ff    <= out_in;
      neg_ff    <= neg_in;
   end

   assign rsp_word = out_ff;
   assign rsp_neg  = neg_ff;

endmodule

// File: rtl/dtdc_ctrl.sv
// dtdc_ctrl: sequencer of the calendar difference unit and owner of the
// result valid flag. Uses dtdc_pkg for the command and status structs.
`timescale 1ns / 1ps

module dtdc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  dtdc_pkg::dtdc_status_type status,
   output dtdc_pkg::dtdc_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_YEAR_IN,
      S_MONTH_IN,
      S_NORM,
      S_HOUR,
      S_MIN,
      S_YEAR_OUT,
      S_MONTH_OUT,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      cmd.op       = dtdc_pkg::OP_IDLE;
      cmd.load     = 1'b0;
      cmd.out_load = 1'b0;

      if (valid_ff && rsp_ready) valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_YEAR_IN;
            end
         end
         S_YEAR_IN: begin
            cmd.op = dtdc_pkg::OP_YEAR_IN;
            if (status.year_in_done) state_in = S_MONTH_IN;
         end
         S_MONTH_IN: begin
            cmd.op = dtdc_pkg::OP_MONTH_IN;
            if (status.month_in_done) state_in = S_NORM;
         end
         S_NORM: begin
            cmd.op = dtdc_pkg::OP_NORM;
            if (status.norm_done) state_in = status.negative ? S_FINISH : S_HOUR;
         end
         S_HOUR: begin
            cmd.op = dtdc_pkg::OP_HOUR;
            if (status.div_last) state_in = S_MIN;
         end
         S_MIN: begin
            cmd.op = dtdc_pkg::OP_MIN;
            if (status.div_last) state_in = S_YEAR_OUT;
         end
         S_YEAR_OUT: begin
            cmd.op = dtdc_pkg::OP_YEAR_OUT;
            if (status.year_out_done) state_in = S_MONTH_OUT;
         end
         S_MONTH_OUT: begin
            cmd.op = dtdc_pkg::OP_MONTH_OUT;
            if (status.month_out_done) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.op = dtdc_pkg::OP_FINISH;
            // result register free or being emptied this cycle
            if (!valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               valid_in     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = valid_ff;

endmodule

// File: rtl/dtdc_checker.sv
// dtdc_checker: port level checks of the calendar difference unit, bound
// to the top level below. Uses dtdc_pkg for field positions.
`timescale 1ns / 1ps

module dtdc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [dtdc_pkg::RSP_W-1:0] rsp_tdata,
   input logic [0:0]                 rsp_tuser
);

   dtdc_pkg::dtdc_rsp_type rsp_word;
   assign rsp_word = dtdc_pkg::dtdc_rsp_type'(rsp_tdata);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // one word at a time: busy right after taking a word
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // negative difference reports the epoch
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_word.diff.year == dtdc_pkg::FIRST_YEAR && rsp_word.diff.month == 4'd1 &&
         rsp_word.diff.day == 5'd1 && rsp_word.diff.hour == '0 &&
         rsp_word.diff.minute == '0 && rsp_word.diff.second == '0)
      else $error("negative result not at epoch");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         rsp_word.diff.month >= 4'd1 && rsp_word.diff.month <= 4'd12 &&
         rsp_word.diff.day >= 5'd1 && rsp_word.diff.hour <= 5'd23 &&
         rsp_word.diff.minute <= 6'd59 && rsp_word.diff.second <= 6'd59)
      else $error("result field out of calendar range");

endmodule

bind datetime_difference_calendar_unit dtdc_checker u_dtdc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: tb/sv/datetime_difference_checker.sv
// datetime_difference_checker: watches the request and response streams of the
// calendar difference unit, predicts each response and compares it field by field.
// Depends on dtdc_pkg for the word layouts and year limits.
`timescale 1ns / 1ps

module datetime_difference_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [dtdc_pkg::REQ_W-1:0] req_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [dtdc_pkg::RSP_W-1:0] rsp_tdata,
   input  logic [0:0]                 rsp_tuser,
   output int                         fail_count,
   output int                         pending
);

   typedef struct packed {
      dtdc_pkg::dtdc_dt_type diff;
      logic                  negative;
   } calendar_diff_type;

   calendar_diff_type expected_diffs[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic bit leap_year(input longint y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   // months past december and month zero have no length
   function automatic longint month_length(input longint y, input longint m);
      longint len;
      case (m)
         1, 3, 5, 7, 8, 10, 12: len = 31;
         4, 6, 9, 11:           len = 30;
         2:                     len = leap_year(y) ? 29 : 28;
         default:               len = 0;
      endcase
      return len;
   endfunction

   function automatic longint seconds_since_epoch(input dtdc_pkg::dtdc_dt_type t);
      longint yr;
      longint days;
      longint y;
      longint m;
      yr = longint'(t.year);
      if (yr < dtdc_pkg::FIRST_YEAR_INT) yr = dtdc_pkg::FIRST_YEAR_INT;
      if (yr > dtdc_pkg::LAST_YEAR_INT) yr = dtdc_pkg::LAST_YEAR_INT;
      days = 0;
      for (y = dtdc_pkg::FIRST_YEAR_INT; y < yr; y++) days += leap_year(y) ? 366 : 365;
      for (m = 1; m < longint'(t.month); m++) days += month_length(yr, m);
      // day zero counts as minus one day
      days += longint'(t.day) - 1;
      return days * 86400 + longint'(t.hour) * 3600 + longint'(t.minute) * 60
             + longint'(t.second);
   endfunction

   function automatic calendar_diff_type predict_difference(
      input dtdc_pkg::dtdc_dt_type a, input dtdc_pkg::dtdc_dt_type b);
      calendar_diff_type r;
      longint span;
      longint sec;
      longint min;
      longint hr;
      longint y;
      longint m;
      span = seconds_since_epoch(a) - seconds_since_epoch(b);
      r.diff.year   = dtdc_pkg::YEAR_W'(dtdc_pkg::FIRST_YEAR_INT);
      r.diff.month  = dtdc_pkg::MONTH_W'(1);
      r.diff.day    = dtdc_pkg::DAY_W'(1);
      r.diff.hour   = '0;
      r.diff.minute = '0;
      r.diff.second = '0;
      r.negative    = 1'b1;
      if (span >= 0) begin
         sec = span % 60;  span /= 60;
         min = span % 60;  span /= 60;
         hr  = span % 24;  span /= 24;
         y = dtdc_pkg::FIRST_YEAR_INT;
         while (span >= (leap_year(y) ? 366 : 365)) begin
            span -= leap_year(y) ? 366 : 365;
            y++;
         end
         m = 1;
         while (span >= month_length(y, m)) begin
            span -= month_length(y, m);
            m++;
         end
         r.diff.year   = dtdc_pkg::YEAR_W'(y);
         r.diff.month  = dtdc_pkg::MONTH_W'(m);
         r.diff.day    = dtdc_pkg::DAY_W'(span + 1);
         r.diff.hour   = dtdc_pkg::HOUR_W'(hr);
         r.diff.minute = dtdc_pkg::MIN_W'(min);
         r.diff.second = dtdc_pkg::SEC_W'(sec);
         r.negative    = 1'b0;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input longint exp, input longint act);
      if (exp != act) begin
         $error("%s: expected %0d, got %0d", name, exp, act);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      dtdc_pkg::dtdc_req_type req;
      dtdc_pkg::dtdc_rsp_type rsp;
      calendar_diff_type      exp;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req = req_tdata;
            expected_diffs.push_back(predict_difference(req.a, req.b));
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp = rsp_tdata;
            if (expected_diffs.size() == 0) begin
               $error("response word with no request outstanding");
               fail_count++;
            end else begin
               exp = expected_diffs.pop_front();
               check_field("diff_year", exp.diff.year, rsp.diff.year);
               check_field("diff_month", exp.diff.month, rsp.diff.month);
               check_field("diff_day", exp.diff.day, rsp.diff.day);
               check_field("diff_hour", exp.diff.hour, rsp.diff.hour);
               check_field("diff_minute", exp.diff.minute, rsp.diff.minute);
               check_field("diff_second", exp.diff.second, rsp.diff.second);
               check_field("negative", exp.negative, rsp_tuser[0]);
            end
         end
         pending <= expected_diffs.size();
      end
   end

endmodule

// File: tb/sv/datetime_difference_calendar_unit_tb.sv
// datetime_difference_calendar_unit_tb: clock, reset, request and response
// drivers for the calendar difference unit, with the checker beside it.
// Depends on dtdc_pkg, datetime_difference_calendar_unit and datetime_difference_checker.
`timescale 1ns / 1ps

module datetime_difference_calendar_unit_tb;

   localparam int RANDOM_PER_PHASE = 212;
   localparam int HOLD_CYCLES      = 2000;
   localparam int CYCLE_LIMIT      = 1500000;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [dtdc_pkg::REQ_W-1:0] req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [dtdc_pkg::RSP_W-1:0] rsp_tdata;
   logic [0:0]                 rsp_tuser;

   int failures;
   int pending;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_req      = 1'b0;
   int cycle_count   = 0;

   always #5 clock = ~clock;

   datetime_difference_calendar_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   datetime_difference_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (failures),
      .pending    (pending)
   );

   function automatic dtdc_pkg::dtdc_dt_type make_dt(input int y, input int mo, input int d,
                                                     input int h, input int mi, input int s);
      dtdc_pkg::dtdc_dt_type t;
      t.year   = dtdc_pkg::YEAR_W'(y);
      t.month  = dtdc_pkg::MONTH_W'(mo);
      t.day    = dtdc_pkg::DAY_W'(d);
      t.hour   = dtdc_pkg::HOUR_W'(h);
      t.minute = dtdc_pkg::MIN_W'(mi);
      t.second = dtdc_pkg::SEC_W'(s);
      return t;
   endfunction

   // wild values fill every bit of every field, the rest stay in range
   function automatic dtdc_pkg::dtdc_dt_type random_dt(input bit wild);
      if (wild)
         return make_dt($urandom_range(0, 4095), $urandom_range(0, 15),
                        $urandom_range(0, 31), $urandom_range(0, 31),
                        $urandom_range(0, 63), $urandom_range(0, 63));
      return make_dt($urandom_range(dtdc_pkg::FIRST_YEAR_INT, dtdc_pkg::LAST_YEAR_INT),
                     $urandom_range(1, 12),
                     $urandom_range(1, 31), $urandom_range(0, 23),
                     $urandom_range(0, 59), $urandom_range(0, 59));
   endfunction

   // called at a falling edge, returns at a falling edge once the word is taken
   task automatic send_word(input dtdc_pkg::dtdc_dt_type a, input dtdc_pkg::dtdc_dt_type b);
      dtdc_pkg::dtdc_req_type w;
      w.pad = '0;
      w.a   = a;
      w.b   = b;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      dtdc_pkg::dtdc_dt_type a;
      dtdc_pkg::dtdc_dt_type b;
      dtdc_pkg::dtdc_dt_type t;
      int pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         a = random_dt(pick < 15);
         b = random_dt(pick >= 10 && pick < 20);
         if (pick >= 20 && pick < 75 && b.year > a.year) begin
            t = a; a = b; b = t;
         end else if (pick >= 75 && pick < 90) begin
            // close pair, result near the epoch
            b = a;
            b.second = dtdc_pkg::SEC_W'($urandom_range(0, 59));
            b.minute = dtdc_pkg::MIN_W'($urandom_range(0, 59));
            if ($urandom_range(0, 1)) b.day = dtdc_pkg::DAY_W'($urandom_range(1, 31));
         end
         send_word(a, b);
      end
   endtask

   // response side: random stalls, plus one long hold-off counted here
   initial begin
      int held;
      bit hold_done;
      held      = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            rsp_tready <= 1'b0;
            held++;
            if (held >= HOLD_CYCLES) hold_done = 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int phase;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words
      send_word(make_dt(1970, 1, 1, 0, 0, 0), make_dt(1970, 1, 1, 0, 0, 0));
      send_word(make_dt(2099, 12, 31, 23, 59, 59), make_dt(1970, 1, 1, 0, 0, 0));
      send_word(make_dt(1970, 1, 1, 0, 0, 0), make_dt(2099, 12, 31, 23, 59, 59));
      send_word(make_dt(1970, 1, 1, 0, 0, 1), make_dt(1970, 1, 1, 0, 0, 0));
      send_word(make_dt(1970, 1, 1, 0, 0, 0), make_dt(1970, 1, 1, 0, 0, 1));
      send_word(make_dt(2000, 3, 1, 0, 0, 0), make_dt(2000, 2, 28, 0, 0, 0));
      send_word(make_dt(2000, 2, 29, 12, 0, 0), make_dt(1970, 1, 1, 0, 0, 0));
      send_word(make_dt(2001, 1, 1, 0, 0, 0), make_dt(2000, 1, 1, 0, 0, 0));
      send_word(make_dt(1971, 1, 1, 0, 0, 0), make_dt(1970, 1, 1, 0, 0, 1));
      // years clamped below and above the range
      send_word(make_dt(0, 6, 15, 10, 20, 30), make_dt(1969, 1, 1, 0, 0, 0));
      send_word(make_dt(4095, 1, 1, 0, 0, 0), make_dt(2100, 1, 1, 0, 0, 0));
      send_word(make_dt(4095, 6, 1, 0, 0, 0), make_dt(2000, 1, 1, 0, 0, 0));
      // month zero and months past december
      send_word(make_dt(1990, 0, 1, 0, 0, 0), make_dt(1990, 1, 1, 0, 0, 0));
      send_word(make_dt(1990, 13, 1, 0, 0, 0), make_dt(1990, 1, 1, 0, 0, 0));
      send_word(make_dt(1992, 15, 1, 0, 0, 0), make_dt(1970, 0, 1, 0, 0, 0));
      // day zero and oversized time fields
      send_word(make_dt(1980, 5, 0, 0, 0, 0), make_dt(1970, 1, 0, 0, 0, 0));
      send_word(make_dt(1970, 1, 1, 31, 63, 63), make_dt(1970, 1, 1, 0, 0, 0));
      send_word(make_dt(1970, 1, 1, 0, 0, 0), make_dt(1970, 1, 0, 0, 0, 0));
      send_word(make_dt(4095, 15, 31, 31, 63, 63), make_dt(0, 0, 0, 0, 0, 0));
      send_word(make_dt(0, 0, 0, 0, 0, 0), make_dt(4095, 15, 31, 31, 63, 63));
      send_word(make_dt(2099, 15, 31, 31, 63, 63), make_dt(1970, 0, 0, 0, 0, 0));
      send_word(make_dt(2050, 7, 31, 23, 59, 59), make_dt(2050, 7, 31, 23, 59, 59));

      // long response hold-off while requests keep coming
      hold_req = 1'b1;
      send_random(12);
      hold_req = 1'b0;

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 72; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 72; end
            default: begin send_idle_pct = 14; rsp_stall_pct = 14; end
         endcase
         send_random(RANDOM_PER_PHASE);
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
